/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared implication checks for the keyed table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/ntbl_pkg.sv */
// ----------------------------------------------------------------------------
// ntbl_pkg
// Types and command codes for the newest-first keyed table.
// ----------------------------------------------------------------------------
package ntbl_pkg;

   localparam int KEY_BITS = 32;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [KEY_BITS-1:0] key;
      logic [31:0]         item_value;
   } ntbl_req_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] read_value;
      logic [4:0]  entries_held;
      logic        overflow;
   } ntbl_rsp_type;

   typedef struct packed {
      logic insert;
      logic del_commit;
      logic scan_done;
   } ntbl_ctl_type;

   typedef struct packed {
      logic active;
      logic found;
   } ntbl_tok_type;

endpackage

/* rtl/ntbl_cell.sv */
// ----------------------------------------------------------------------------
// ntbl_cell
// One table slot: holds a pair, compares against a passing search token and
// shifts toward either neighbor on insert or delete.
// ----------------------------------------------------------------------------
module ntbl_cell
   import ntbl_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ntbl_ctl_type          ctl,
   input  logic [KEY_BITS-1:0]   search_key,
   input  logic [KEY_BITS-1:0]   prev_key,
   input  logic [VALUE_BITS-1:0] prev_value,
   input  logic                  prev_valid,
   input  logic [KEY_BITS-1:0]   next_key,
   input  logic [VALUE_BITS-1:0] next_value,
   input  logic                  next_valid,
   input  ntbl_tok_type          tok_in,
   input  logic [VALUE_BITS-1:0] tok_value_in,
   output ntbl_tok_type          tok_out,
   output logic [VALUE_BITS-1:0] tok_value_out,
   output logic [KEY_BITS-1:0]   key,
   output logic [VALUE_BITS-1:0] value,
   output logic                  valid
);

   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  valid_ff;
   logic                  mark_ff;
   ntbl_tok_type          tok_ff;
   logic [VALUE_BITS-1:0] tok_value_ff;
   logic                  match;
   logic                  mark_now;

   assign match    = tok_ff.active && !tok_ff.found && valid_ff && (key_ff == search_key);
   assign mark_now = tok_ff.active && (tok_ff.found || match);

   always_comb begin
      tok_out.active = tok_ff.active;
      tok_out.found  = tok_ff.found || match;
      tok_value_out  = match ? value_ff : tok_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         mark_ff       <= 1'b0;
         tok_ff.active <= 1'b0;
         tok_ff.found  <= 1'b0;
      end else begin
         tok_ff <= tok_in;
         if (ctl.insert) begin
            valid_ff <= prev_valid;
         end else if (ctl.del_commit && (mark_ff || mark_now)) begin
            valid_ff <= next_valid;
         end
         if (ctl.scan_done) begin
            mark_ff <= 1'b0;
         end else if (mark_now) begin
            mark_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      tok_value_ff <= tok_value_in;
      if (ctl.insert) begin
         key_ff   <= prev_key;
         value_ff <= prev_value;
      end else if (ctl.del_commit && (mark_ff || mark_now)) begin
         key_ff   <= next_key;
         value_ff <= next_value;
      end
   end

   assign key   = key_ff;
   assign value = value_ff;
   assign valid = valid_ff;

endmodule

/* rtl/newest_first_keyed_table.sv */
// ----------------------------------------------------------------------------
// newest_first_keyed_table
// Bounded key/value table in newest-first order with insert, delete, lookup.
// ----------------------------------------------------------------------------
// An insert (or an unused command code) needs no search: its result strobes
// on the cycle after acceptance and busy never rises, so another item may
// start at once. A delete or lookup sends a search token down the chain of
// DEPTH cells, one cell per cycle: busy stays high while the token travels
// and the result is registered once it leaves the last cell; a delete closes
// its gap at the same edge. Each result is shown for one cycle only and cannot
// be held off, so the receiver must take it then.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module newest_first_keyed_table
   import ntbl_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  ntbl_req_type req_item,
   output logic         rsp_strobe,
   output ntbl_rsp_type rsp_item
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                  state_ff, state_in;
   logic [1:0]            cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   ntbl_rsp_type          rsp_ff, rsp_in;

   logic                  accept;
   logic                  full;
   logic                  scan_done;
   ntbl_ctl_type          ctl;
   logic [VALUE_BITS-1:0] store_value;
   logic [VALUE_BITS+31:0] store_pad;
   logic [VALUE_BITS+31:0] read_pad;
   logic [CNT_BITS+4:0]   count_pad;

   logic [KEY_BITS-1:0]   cell_key   [DEPTH];
   logic [VALUE_BITS-1:0] cell_value [DEPTH];
   logic                  cell_valid [DEPTH];
   ntbl_tok_type          tok_link   [DEPTH+1];
   logic [VALUE_BITS-1:0] tok_val_link [DEPTH+1];

   assign accept    = start && (state_ff == ST_IDLE);
   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign scan_done = (state_ff == ST_SCAN) && tok_link[DEPTH].active;

   assign store_pad   = {{VALUE_BITS{1'b0}}, req_item.item_value};
   assign store_value = store_pad[VALUE_BITS-1:0];
   assign read_pad    = {32'b0, tok_val_link[DEPTH]};

   always_comb begin
      ctl.insert     = accept && (req_item.cmd == CMD_INSERT) && !full;
      ctl.scan_done  = scan_done;
      ctl.del_commit = scan_done && (cmd_ff == CMD_DELETE) && tok_link[DEPTH].found;
   end

   always_comb begin
      tok_link[0].active = accept &&
                           ((req_item.cmd == CMD_DELETE) || (req_item.cmd == CMD_LOOKUP));
      tok_link[0].found  = 1'b0;
      tok_val_link[0]    = '0;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_BITS-1:0]   p_key, n_key;
      logic [VALUE_BITS-1:0] p_value, n_value;
      logic                  p_valid, n_valid;

      if (i == 0) begin : g_head
         assign p_key   = req_item.key;
         assign p_value = store_value;
         assign p_valid = 1'b1;
      end else begin : g_body
         assign p_key   = cell_key[i-1];
         assign p_value = cell_value[i-1];
         assign p_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign n_key   = '0;
         assign n_value = '0;
         assign n_valid = 1'b0;
      end else begin : g_mid
         assign n_key   = cell_key[i+1];
         assign n_value = cell_value[i+1];
         assign n_valid = cell_valid[i+1];
      end

      ntbl_cell #(
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .search_key    (key_ff),
         .prev_key      (p_key),
         .prev_value    (p_value),
         .prev_valid    (p_valid),
         .next_key      (n_key),
         .next_value    (n_value),
         .next_valid    (n_valid),
         .tok_in        (tok_link[i]),
         .tok_value_in  (tok_val_link[i]),
         .tok_out       (tok_link[i+1]),
         .tok_value_out (tok_val_link[i+1]),
         .key           (cell_key[i]),
         .value         (cell_value[i]),
         .valid         (cell_valid[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      rsp_in.hit        = 1'b0;
      rsp_in.read_value = '0;
      rsp_in.overflow   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req_item.cmd;
               key_in = req_item.key;
               unique case (req_item.cmd)
                  CMD_INSERT: begin
                     rsp_strobe_in = 1'b1;
                     if (full) begin
                        rsp_in.overflow = 1'b1;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_DELETE, CMD_LOOKUP: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_in.hit    = tok_link[DEPTH].found;
               if (cmd_ff == CMD_LOOKUP && tok_link[DEPTH].found) begin
                  rsp_in.read_value = read_pad[31:0];
               end
               if (ctl.del_commit) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      count_pad           = {5'b0, count_in};
      rsp_in.entries_held = count_pad[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff == ST_SCAN);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   `ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_BITS'(DEPTH))
   `ASSERT_IMPLY(a_ovf_full, clock, reset, rsp_strobe && rsp_item.overflow, full)
   `ASSERT_NEXT(a_insert_resp, clock, reset, accept && (req_item.cmd == CMD_INSERT), rsp_strobe && !busy)
   `ASSERT_NEXT(a_scan_resp, clock, reset, scan_done, rsp_strobe && !busy)
   `ASSERT_IMPLY(a_tok_one, clock, reset, busy, $countones({tok_link[0].active, scan_done}) <= 1)

endmodule
